FILE: rtl/dqr_pkg.sv
// package for the deque with lazy reversal: sizes, request and status codes,
// the command record passed from front to back, and circular slot arithmetic
// no dependencies
package dqr_pkg;

  localparam int DEPTH    = 32;
  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = $clog2(DEPTH + 1);
  localparam int ELEM_W   = 16;
  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_REVERSE = 2'd1,
    REQ_DELETE  = 2'd2,
    REQ_EMIT    = 2'd3
  } req_t;

  // ST_ELEM doubles as "no error" in the sticky error register
  typedef enum logic [1:0] {
    ST_ELEM    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_DEL_ERR = 2'd2,
    ST_OVF_ERR = 2'd3
  } status_t;

  typedef struct packed {
    req_t              req;
    logic [ELEM_W-1:0] value;
  } cmd_t;

  function automatic logic [AW-1:0] slot_add(logic [AW-1:0] base, logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_inc(logic [AW-1:0] s);
    return (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_dec(logic [AW-1:0] s);
    return (s == '0) ? AW'(DEPTH - 1) : s - AW'(1);
  endfunction

endpackage

FILE: rtl/deque_with_reverse_flag.sv
// top level of the deque with lazy reversal: front end, command queue, back end
// throughput: push, reverse and delete retire one per cycle while the back end is free;
// an emit of n elements holds the back end until its last element is loaded and streams
// one element per cycle once started while the output is accepted, paced by the single
// read port of the element store; an empty or error emit gives one status transaction;
// reset: pointers, count, reversal flag, error and all queues clear
module deque_with_reverse_flag (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // value
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // elem_value
  output logic [1:0]  out_tuser,  // status
  output logic        out_tlast   // last
);
  import dqr_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  dqr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  dqr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/dqr_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module dqr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/dqr_front.sv
// front end: takes input transactions, decodes the request kind and queues
// commands for the back end; uses dqr_pkg
module dqr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [15:0]   in_tdata,   // value
  input  logic [1:0]    in_tuser,   // req_type
  output logic          cmd_valid,
  output dqr_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import dqr_pkg::*;

  cmd_t             q_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CW-1:0] cnt_r, cnt_nxt;
  logic             push, pop;
  cmd_t             in_cmd;

  assign in_tready = (cnt_r != CQ_CW'(CQ_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_pop && cmd_valid;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    unique case (in_tuser)
      2'd0:    in_cmd.req = REQ_PUSH;
      2'd1:    in_cmd.req = REQ_REVERSE;
      2'd2:    in_cmd.req = REQ_DELETE;
      default: in_cmd.req = REQ_EMIT;
    endcase
    in_cmd.value = in_tdata[ELEM_W-1:0];
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + CQ_AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + CQ_AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CQ_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

FILE: rtl/dqr_back.sv
// back end: executes queued commands on the circular element store, walks
// the store for an emit and drives the result register; uses dqr_pkg, dqr_ram
module dqr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  dqr_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [15:0]   out_tdata,  // elem_value
  output logic [1:0]    out_tuser,  // status
  output logic          out_tlast   // last
);
  import dqr_pkg::*;

  typedef enum logic [1:0] {
    S_EXEC = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              rev_r, rev_nxt;
  status_t           err_r, err_nxt;

  // emit walk
  logic [AW-1:0]     rd_slot_r, rd_slot_nxt;
  logic [CW-1:0]     remain_r, remain_nxt;
  logic              walk_rev_r, walk_rev_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              last_pend_r, last_pend_nxt;

  // result register
  logic              ov_r, ov_nxt;
  logic [ELEM_W-1:0] od_r, od_nxt;
  status_t           os_r, os_nxt;
  logic              ol_r, ol_nxt;

  logic              out_free;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [ELEM_W-1:0] ram_rdata;
  logic              has_err, load;

  dqr_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.value),
    .re    (ram_re),
    .raddr (rd_slot_r),
    .rdata (ram_rdata)
  );

  assign out_free = !ov_r || out_tready;
  assign has_err  = (err_r != ST_ELEM);
  assign load     = (state_r == S_EMIT) && rd_pend_r && out_free;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    err_nxt       = err_r;
    rd_slot_nxt   = rd_slot_r;
    remain_nxt    = remain_r;
    walk_rev_nxt  = walk_rev_r;
    rd_pend_nxt   = rd_pend_r;
    last_pend_nxt = last_pend_r;
    ov_nxt        = ov_r && !out_tready;
    od_nxt        = od_r;
    os_nxt        = os_r;
    ol_nxt        = ol_r;
    cmd_pop       = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = slot_add(head_r, AW'(count_r));

    unique case (state_r)
      S_EXEC: begin
        if (cmd_valid) begin
          unique case (cmd.req)
            REQ_PUSH: begin
              cmd_pop = 1'b1;
              if (!has_err) begin
                if (count_r == CW'(DEPTH)) begin
                  err_nxt = ST_OVF_ERR;
                end else begin
                  ram_we    = 1'b1;
                  count_nxt = count_r + CW'(1);
                end
              end
            end
            REQ_REVERSE: begin
              cmd_pop = 1'b1;
              if (!has_err) begin
                rev_nxt = !rev_r;
              end
            end
            REQ_DELETE: begin
              cmd_pop = 1'b1;
              if (!has_err) begin
                if (count_r == '0) begin
                  err_nxt = ST_DEL_ERR;
                end else begin
                  if (!rev_r) begin
                    head_nxt = slot_inc(head_r);
                  end
                  count_nxt = count_r - CW'(1);
                end
              end
            end
            REQ_EMIT: begin
              if (has_err || count_r == '0) begin
                // single status transaction
                if (out_free) begin
                  cmd_pop = 1'b1;
                  ov_nxt  = 1'b1;
                  od_nxt  = '0;
                  os_nxt  = has_err ? err_r : ST_EMPTY;
                  ol_nxt  = 1'b1;
                end
              end else begin
                cmd_pop      = 1'b1;
                state_nxt    = S_EMIT;
                remain_nxt   = count_r;
                walk_rev_nxt = rev_r;
                rd_pend_nxt  = 1'b0;
                rd_slot_nxt  = rev_r ? slot_add(head_r, AW'(count_r - CW'(1))) : head_r;
              end
              if (cmd_pop) begin
                head_nxt  = '0;
                count_nxt = '0;
                rev_nxt   = 1'b0;
                err_nxt   = ST_ELEM;
              end
            end
            default: ;
          endcase
        end
      end

      S_EMIT: begin
        if (load) begin
          ov_nxt      = 1'b1;
          od_nxt      = ram_rdata;
          os_nxt      = ST_ELEM;
          ol_nxt      = last_pend_r;
          rd_pend_nxt = 1'b0;
          if (remain_r == '0) begin
            state_nxt = S_EXEC;
          end
        end
        // keep the read port busy while the result slot drains
        if (remain_r != '0 && (!rd_pend_r || load)) begin
          ram_re        = 1'b1;
          rd_pend_nxt   = 1'b1;
          last_pend_nxt = (remain_r == CW'(1));
          remain_nxt    = remain_r - CW'(1);
          rd_slot_nxt   = walk_rev_r ? slot_dec(rd_slot_r) : slot_inc(rd_slot_r);
        end
      end

      default: state_nxt = S_EXEC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_EXEC;
      head_r    <= '0;
      count_r   <= '0;
      rev_r     <= 1'b0;
      err_r     <= ST_ELEM;
      remain_r  <= '0;
      rd_pend_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      rev_r     <= rev_nxt;
      err_r     <= err_nxt;
      remain_r  <= remain_nxt;
      rd_pend_r <= rd_pend_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r   <= rd_slot_nxt;
    walk_rev_r  <= walk_rev_nxt;
    last_pend_r <= last_pend_nxt;
    od_r        <= od_nxt;
    os_r        <= os_nxt;
    ol_r        <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = 16'(od_r);
  assign out_tuser  = os_r;
  assign out_tlast  = ol_r;

endmodule

FILE: tb/sv/tb_top.sv
// testbench for deque_with_reverse_flag: drives push, reverse, delete and emit commands,
// keeps its own copy of the deque and checks every emitted transaction in order
// depends on dqr_pkg and deque_with_reverse_flag
module tb_top;
  import dqr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int EXP_DEPTH   = 1024;

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    status_t           status;
    logic              last;
  } emit_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata = '0;
  logic [1:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;
  logic [1:0]        out_tuser;
  logic              out_tlast;

  // software copy of the deque
  logic [ELEM_W-1:0] dq_store [DEPTH];
  logic [AW-1:0]     dq_head = '0;
  logic [CW-1:0]     dq_count = '0;
  logic              dq_rev = 1'b0;
  status_t           dq_err = ST_ELEM;

  // expected results, circular with running write and read counts
  emit_item_t        exp_fifo [EXP_DEPTH];
  int                exp_wr = 0;
  int                exp_rd = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int fail_count = 0;
  int cycle_count = 0;

  deque_with_reverse_flag dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(string msg);
    if (fail_count < 100) begin
      $display("mismatch: %s", msg);
    end
    fail_count++;
  endtask

  function automatic void exp_put(emit_item_t r);
    exp_fifo[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endfunction

  always @(posedge clk) begin
    emit_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_wr == exp_rd) begin
        report_mismatch($sformatf("unexpected result value=%h status=%0d last=%0b",
                                  out_tdata, out_tuser, out_tlast));
      end else begin
        want = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_tdata !== want.value || out_tuser !== want.status ||
            out_tlast !== want.last) begin
          report_mismatch($sformatf("got value=%h status=%0d last=%0b, want %h %0d %0b",
                                    out_tdata, out_tuser, out_tlast,
                                    want.value, want.status, want.last));
        end
      end
    end
  end

  function automatic void run_deque_cmd(req_t req, logic [ELEM_W-1:0] val);
    int i;
    int off;
    int slot;
    emit_item_t r;
    if (req == REQ_EMIT) begin
      if (dq_err != ST_ELEM) begin
        r = '{'0, dq_err, 1'b1};
        exp_put(r);
      end else if (dq_count == 0) begin
        r = '{'0, ST_EMPTY, 1'b1};
        exp_put(r);
      end else begin
        for (i = 0; i < int'(dq_count); i++) begin
          off = dq_rev ? int'(dq_count) - 1 - i : i;
          slot = (int'(dq_head) + off) % DEPTH;
          r = '{dq_store[slot], ST_ELEM, (i == int'(dq_count) - 1)};
          exp_put(r);
        end
      end
      dq_head = '0;
      dq_count = '0;
      dq_rev = 1'b0;
      dq_err = ST_ELEM;
      return;
    end
    // a pending error swallows everything but emit
    if (dq_err != ST_ELEM) return;
    case (req)
      REQ_PUSH: begin
        if (int'(dq_count) >= DEPTH) begin
          dq_err = ST_OVF_ERR;
        end else begin
          dq_store[(int'(dq_head) + int'(dq_count)) % DEPTH] = val;
          dq_count = dq_count + 1'b1;
        end
      end
      REQ_REVERSE: begin
        dq_rev = ~dq_rev;
      end
      default: begin
        if (dq_count == 0) begin
          dq_err = ST_DEL_ERR;
        end else begin
          if (!dq_rev) dq_head = AW'((int'(dq_head) + 1) % DEPTH);
          dq_count = dq_count - 1'b1;
        end
      end
    endcase
  endfunction

  // caller stands just after a rising edge; valid stays up for back-to-back transactions
  task automatic send_cmd(req_t req, logic [ELEM_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    run_deque_cmd(req, val);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (exp_wr != exp_rd) @(posedge clk);
  endtask

  function automatic logic [ELEM_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return ELEM_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic test_basic_commands();
    send_cmd(REQ_EMIT, 16'h1234);
    send_cmd(REQ_PUSH, 16'h0000);
    send_cmd(REQ_PUSH, 16'hFFFF);
    send_cmd(REQ_PUSH, 16'h5555);
    send_cmd(REQ_REVERSE, 16'hAAAA);
    send_cmd(REQ_EMIT, 16'h0000);
    // delete on empty, then the ignored commands
    send_cmd(REQ_DELETE, 16'hFFFF);
    send_cmd(REQ_PUSH, 16'hAAAA);
    send_cmd(REQ_REVERSE, 16'h0000);
    send_cmd(REQ_DELETE, 16'h0000);
    send_cmd(REQ_EMIT, 16'h0000);
    // front delete, then back delete while reversed
    send_cmd(REQ_PUSH, 16'h000A);
    send_cmd(REQ_PUSH, 16'h000B);
    send_cmd(REQ_PUSH, 16'h000C);
    send_cmd(REQ_DELETE, 16'h0000);
    send_cmd(REQ_REVERSE, 16'h0000);
    send_cmd(REQ_DELETE, 16'h0000);
    send_cmd(REQ_PUSH, 16'h000D);
    send_cmd(REQ_EMIT, 16'h0000);
  endtask

  task automatic test_full_queue();
    repeat (DEPTH) send_cmd(REQ_PUSH, rand_value());
    send_cmd(REQ_PUSH, 16'hBEEF);
    send_cmd(REQ_DELETE, 16'h0000);
    send_cmd(REQ_REVERSE, 16'h0000);
    send_cmd(REQ_EMIT, 16'h0000);
    // move the head off zero so a full emit wraps around the store
    send_cmd(REQ_PUSH, 16'h0001);
    send_cmd(REQ_PUSH, 16'h0002);
    send_cmd(REQ_DELETE, 16'h0000);
    send_cmd(REQ_DELETE, 16'h0000);
    repeat (DEPTH) send_cmd(REQ_PUSH, rand_value());
    send_cmd(REQ_REVERSE, 16'h0000);
    send_cmd(REQ_EMIT, 16'h0000);
    send_cmd(REQ_EMIT, 16'h0000);
  endtask

  task automatic test_output_hold();
    int saved;
    saved = recv_idle_pct;
    recv_idle_pct = 0;
    hold_request = 300;
    repeat (DEPTH) send_cmd(REQ_PUSH, rand_value());
    send_cmd(REQ_EMIT, 16'h0000);
    repeat (20) send_cmd(REQ_PUSH, rand_value());
    send_cmd(REQ_REVERSE, 16'h0000);
    send_cmd(REQ_EMIT, 16'h0000);
    send_cmd(REQ_EMIT, 16'h0000);
    wait_drained();
    recv_idle_pct = saved;
  endtask

  task automatic test_drain_pause();
    repeat (5) send_cmd(REQ_PUSH, rand_value());
    send_cmd(REQ_EMIT, 16'h0000);
    wait_drained();
    send_cmd(REQ_DELETE, 16'h0000);
    send_cmd(REQ_EMIT, 16'h0000);
    wait_drained();
  endtask

  task automatic test_random(int n_items, int s_pct, int r_pct);
    int sent;
    int target;
    int pushes;
    int r;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 8) begin
        // well-formed run ending in an emit; now and then long enough to overflow
        target = ($urandom_range(9) == 0) ? $urandom_range(DEPTH + 1, DEPTH - 8)
                                          : $urandom_range(12);
        pushes = 0;
        while (pushes < target) begin
          r = $urandom_range(99);
          if (r < 65 || (r >= 80 && dq_count == 0)) begin
            send_cmd(REQ_PUSH, rand_value());
            pushes++;
          end else if (r < 80) begin
            send_cmd(REQ_REVERSE, rand_value());
          end else begin
            send_cmd(REQ_DELETE, rand_value());
          end
          sent++;
        end
        send_cmd(REQ_EMIT, rand_value());
        sent++;
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_cmd(req_t'($urandom_range(3)), rand_value());
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 25;
    recv_idle_pct = 61;
    test_basic_commands();
    test_full_queue();
    test_output_hold();
    test_drain_pause();
    test_random(100, 25, 61);
    test_random(100, 61, 25);
    test_random(100, 0, 0);
    send_cmd(REQ_EMIT, 16'h0000);
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
